// ===== src/protection_region_map_insert_macros.svh =====
// Assertion macros for the protection region map insert block.
// Used by the checker; expects clk and rst_n in the scope of each use.
`ifndef PROTECTION_REGION_MAP_INSERT_MACROS_SVH
`define PROTECTION_REGION_MAP_INSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PRMI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PRMI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/prmi_pkg.sv =====
// Shared types and constants for the protection region map insert block.
// No dependencies; compiled before every other file.
package prmi_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_ADDR_BITS   = 48;
    localparam int ATTR_W          = 16;
    localparam int IDX_W           = 4;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_INSERT = 2'd2,
        OP_READ   = 2'd3
    } prmi_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BOUNDS   = 2'd1,
        ST_NOREGION = 2'd2,
        ST_FULL     = 2'd3
    } prmi_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_DECIDE,
        S_WRITE,
        S_READ,
        S_DONE
    } prmi_state_t;

    // How the matched entry is rewritten
    typedef enum logic [2:0] {
        K_EXACT,
        K_SPLIT_BASE,
        K_SPLIT_LIMIT,
        K_SPLIT3,
        K_APPEND
    } prmi_kind_t;

endpackage

// ===== src/prmi_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on prmi_pkg.
interface prmi_req_if #(
    parameter int ADDR_BITS = prmi_pkg::DEF_ADDR_BITS
);
    import prmi_pkg::*;

    logic                  valid;
    logic                  ready;
    prmi_op_t              op;
    logic [ADDR_BITS-1:0]  base;
    logic [ADDR_BITS-1:0]  size;
    logic [ATTR_W-1:0]     attr;
    logic [IDX_W-1:0]      entry_index;

    modport source (output valid, op, base, size, attr, entry_index, input ready);
    modport sink   (input valid, op, base, size, attr, entry_index, output ready);
endinterface

interface prmi_rsp_if #(
    parameter int MAX_ENTRIES = prmi_pkg::DEF_MAX_ENTRIES,
    parameter int ADDR_BITS   = prmi_pkg::DEF_ADDR_BITS
);
    import prmi_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic                  valid;
    logic                  ready;
    prmi_status_t          status;
    logic [CW-1:0]         entry_count;
    logic [ADDR_BITS-1:0]  read_base;
    logic [ADDR_BITS:0]    read_limit;
    logic [ATTR_W-1:0]     read_attr;

    modport source (output valid, status, entry_count, read_base, read_limit, read_attr,
                    input ready);
    modport sink   (input valid, status, entry_count, read_base, read_limit, read_attr,
                    output ready);
endinterface

// ===== src/protection_region_map_insert.sv =====
// Top level of the protection region map insert block: sequencer and result register.
// Depends on prmi_pkg, prmi_if (prmi_req_if, prmi_rsp_if) and prmi_mem.
//
//  channel | dir | transfer content
//  --------+-----+----------------------------------------------
//  req     | in  | op, base, size, attr, entry_index
//  rsp     | out | status, entry_count, read_base/limit/attr
//
// Clear goes from EXEC to DONE; append writes in WRITE and read fetches in READ, unless rejected.
// Insert scans in SEARCH: the single comparator checks one entry per cycle
// through the table's one read port, then DECIDE picks the rewrite and one to three table
// writes go through the one write port (none when a three-way split finds the table
// full). An insert with no containing region, or on a full table, makes no write.
// Reset clears the entry count and the sequencer; table contents are kept.
// A result held by a stalled rsp blocks the load of the next result; the sequencer waits in DONE and takes no request.
module protection_region_map_insert #(
    parameter int MAX_ENTRIES = prmi_pkg::DEF_MAX_ENTRIES,
    parameter int ADDR_BITS   = prmi_pkg::DEF_ADDR_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    prmi_req_if.sink        req,
    prmi_rsp_if.source      rsp
);
    import prmi_pkg::*;

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int EW   = ADDR_BITS + 1;
    localparam int DW   = 2 * EW + ATTR_W;
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    // Sequencer and captured request
    prmi_state_t         state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    prmi_op_t            op_reg, op_next;
    logic [ADDR_BITS-1:0] b_reg, b_next;
    logic [EW-1:0]       l_reg, l_next;
    logic [ATTR_W-1:0]   a_reg, a_next;
    logic [IDX_W-1:0]    ri_reg, ri_next;

    // Search and rewrite
    logic [CW-1:0]       scan_reg, scan_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]       hit_idx_reg, hit_idx_next;
    logic [EW-1:0]       hit_base_reg, hit_base_next;
    logic [EW-1:0]       hit_limit_reg, hit_limit_next;
    logic [ATTR_W-1:0]   hit_attr_reg, hit_attr_next;
    prmi_kind_t          kind_reg, kind_next;
    logic [1:0]          step_reg, step_next;
    logic [1:0]          last_reg, last_next;

    // Staged result
    prmi_status_t        res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0] res_base_reg, res_base_next;
    logic [EW-1:0]       res_limit_reg, res_limit_next;
    logic [ATTR_W-1:0]   res_attr_reg, res_attr_next;

    // Output register
    logic                rsp_valid_reg, rsp_valid_next;
    prmi_status_t        rsp_status_reg, rsp_status_next;
    logic [CW-1:0]       rsp_count_reg, rsp_count_next;
    logic [ADDR_BITS-1:0] rsp_base_reg, rsp_base_next;
    logic [EW-1:0]       rsp_limit_reg, rsp_limit_next;
    logic [ATTR_W-1:0]   rsp_attr_reg, rsp_attr_next;

    // Table port signals
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [DW-1:0]       mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [DW-1:0]       mem_rdata;

    logic [EW-1:0]       rd_base;
    logic [EW-1:0]       rd_limit;
    logic [ATTR_W-1:0]   rd_attr;
    logic [EW-1:0]       b_ext;
    logic [CMPW-1:0]     ri_ext;
    logic [CMPW-1:0]     count_ext;
    logic                hit;
    logic [CW-1:0]       scan_prev;
    logic [CW-1:0]       count_p1;
    logic [CW:0]         count_p2;
    logic [CW-1:0]       inc;

    prmi_mem #(
        .DEPTH  (MAX_ENTRIES),
        .DATA_W (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Unpack entry word and form shared operands
    assign rd_base   = mem_rdata[DW-1 -: EW];
    assign rd_limit  = mem_rdata[ATTR_W +: EW];
    assign rd_attr   = mem_rdata[ATTR_W-1:0];
    assign b_ext     = {1'b0, b_reg};
    assign ri_ext    = CMPW'(ri_reg);
    assign count_ext = CMPW'(count_reg);
    assign scan_prev = scan_reg - CW'(1);
    assign count_p1  = count_reg + CW'(1);
    assign count_p2  = {1'b0, count_reg} + (CW+1)'(2);

    // Shared containment compare
    assign hit = (b_ext >= rd_base) && (l_reg <= rd_limit);

    // Count growth per rewrite kind
    always_comb
    begin
        case (kind_reg)
            K_EXACT:  inc = CW'(0);
            K_SPLIT3: inc = CW'(2);
            default:  inc = CW'(1);
        endcase
    end

    // Register control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Register payload and working state
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        b_reg          <= b_next;
        l_reg          <= l_next;
        a_reg          <= a_next;
        ri_reg         <= ri_next;
        scan_reg       <= scan_next;
        cmp_vld_reg    <= cmp_vld_next;
        hit_idx_reg    <= hit_idx_next;
        hit_base_reg   <= hit_base_next;
        hit_limit_reg  <= hit_limit_next;
        hit_attr_reg   <= hit_attr_next;
        kind_reg       <= kind_next;
        step_reg       <= step_next;
        last_reg       <= last_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
        res_limit_reg  <= res_limit_next;
        res_attr_reg   <= res_attr_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_base_reg   <= rsp_base_next;
        rsp_limit_reg  <= rsp_limit_next;
        rsp_attr_reg   <= rsp_attr_next;
    end

    // Sequence the operation
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        b_next          = b_reg;
        l_next          = l_reg;
        a_next          = a_reg;
        ri_next         = ri_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = cmp_vld_reg;
        hit_idx_next    = hit_idx_reg;
        hit_base_next   = hit_base_reg;
        hit_limit_next  = hit_limit_reg;
        hit_attr_next   = hit_attr_reg;
        kind_next       = kind_reg;
        step_next       = step_reg;
        last_next       = last_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;
        res_limit_next  = res_limit_reg;
        res_attr_next   = res_attr_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_base_next   = rsp_base_reg;
        rsp_limit_next  = rsp_limit_reg;
        rsp_attr_next   = rsp_attr_reg;
        req.ready       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = hit_idx_reg;
        mem_wdata       = {b_ext, l_reg, a_reg};
        mem_raddr       = scan_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                // Take the request and form the exclusive limit
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next    = req.op;
                    b_next     = req.base;
                    l_next     = {1'b0, req.base} + {1'b0, req.size};
                    a_next     = req.attr;
                    ri_next    = req.entry_index;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = ST_OK;
                res_base_next   = '0;
                res_limit_next  = '0;
                res_attr_next   = '0;
                unique case (op_reg)
                    OP_CLEAR:
                    begin
                        count_next = '0;
                        state_next = S_DONE;
                    end
                    OP_APPEND:
                    begin
                        if (count_reg >= CW'(MAX_ENTRIES))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            kind_next  = K_APPEND;
                            step_next  = 2'd1;
                            last_next  = 2'd1;
                            state_next = S_WRITE;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (count_reg >= CW'(MAX_ENTRIES))
                        begin
                            res_status_next = ST_BOUNDS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            scan_next    = '0;
                            cmp_vld_next = 1'b0;
                            state_next   = S_SEARCH;
                        end
                    end
                    OP_READ:
                    begin
                        if ((ri_ext >= count_ext) || (ri_ext >= CMPW'(MAX_ENTRIES)))
                        begin
                            res_status_next = ST_BOUNDS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            mem_raddr  = ri_ext[AW-1:0];
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_READ:
            begin
                res_base_next  = rd_base[ADDR_BITS-1:0];
                res_limit_next = rd_limit;
                res_attr_next  = rd_attr;
                state_next     = S_DONE;
            end

            S_SEARCH:
            begin
                // Issue one address and check the previous entry each cycle
                if (cmp_vld_reg && hit)
                begin
                    hit_idx_next   = scan_prev[AW-1:0];
                    hit_base_next  = rd_base;
                    hit_limit_next = rd_limit;
                    hit_attr_next  = rd_attr;
                    state_next     = S_DECIDE;
                end
                else if (scan_reg < count_reg)
                begin
                    scan_next    = scan_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                end
                else
                begin
                    res_status_next = ST_NOREGION;
                    state_next      = S_DONE;
                end
            end

            S_DECIDE:
            begin
                // Pick exact match, two-way or three-way split, or reject a three-way split on a full table
                step_next  = 2'd0;
                state_next = S_WRITE;
                if ((b_ext == hit_base_reg) && (l_reg == hit_limit_reg))
                begin
                    kind_next = K_EXACT;
                    last_next = 2'd0;
                end
                else if (b_ext == hit_base_reg)
                begin
                    kind_next = K_SPLIT_BASE;
                    last_next = 2'd1;
                end
                else if (l_reg == hit_limit_reg)
                begin
                    kind_next = K_SPLIT_LIMIT;
                    last_next = 2'd1;
                end
                else if (count_p2 > (CW+1)'(MAX_ENTRIES))
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    kind_next = K_SPLIT3;
                    last_next = 2'd2;
                end
            end

            S_WRITE:
            begin
                // Write one entry per cycle
                mem_we = 1'b1;
                case (step_reg)
                    2'd0:
                    begin
                        mem_waddr = hit_idx_reg;
                        case (kind_reg)
                            K_EXACT:      mem_wdata = {b_ext, l_reg, a_reg};
                            K_SPLIT_BASE: mem_wdata = {l_reg, hit_limit_reg, hit_attr_reg};
                            default:      mem_wdata = {hit_base_reg, b_ext, hit_attr_reg};
                        endcase
                    end
                    2'd1:
                    begin
                        mem_waddr = count_reg[AW-1:0];
                        mem_wdata = {b_ext, l_reg, a_reg};
                    end
                    2'd2:
                    begin
                        mem_waddr = count_p1[AW-1:0];
                        mem_wdata = {l_reg, hit_limit_reg, hit_attr_reg};
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
                if (step_reg == last_reg)
                begin
                    count_next      = count_reg + inc;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end

            S_DONE:
            begin
                // Load the output register once it is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_count_next  = count_reg;
                    rsp_base_next   = res_base_reg;
                    rsp_limit_next  = res_limit_reg;
                    rsp_attr_next   = res_attr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Drive the response channel
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.entry_count = rsp_count_reg;
    assign rsp.read_base   = rsp_base_reg;
    assign rsp.read_limit  = rsp_limit_reg;
    assign rsp.read_attr   = rsp_attr_reg;

endmodule

// ===== src/prmi_mem.sv =====
// Region table storage: one write port, one read port with registered data.
// Depends on nothing; sized by its parameters.
module prmi_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 114
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/prmi_chk.sv =====
// Port-level checker for protection_region_map_insert, bound to the top level.
// Depends on prmi_pkg and protection_region_map_insert_macros.svh.
`include "protection_region_map_insert_macros.svh"

module prmi_chk #(
    parameter int MAX_ENTRIES = prmi_pkg::DEF_MAX_ENTRIES,
    parameter int ADDR_BITS   = prmi_pkg::DEF_ADDR_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    input  logic                                 req_ready,
    input  logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    input  prmi_pkg::prmi_status_t               rsp_status,
    input  logic [$clog2(MAX_ENTRIES + 1)-1:0]   rsp_entry_count,
    input  logic [ADDR_BITS-1:0]                 rsp_read_base,
    input  logic [ADDR_BITS:0]                   rsp_read_limit,
    input  logic [prmi_pkg::ATTR_W-1:0]          rsp_read_attr
);
    import prmi_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // The table never reports more entries than it holds
    `PRMI_ASSERT_SAME(a_count_in_range, rsp_valid, rsp_entry_count <= CW'(MAX_ENTRIES), "entry count above table depth")

    // Read fields stay zero on every failed operation
    `PRMI_ASSERT_SAME(a_fields_zero_on_error, rsp_valid && (rsp_status != ST_OK), (rsp_read_base == '0) && (rsp_read_limit == '0) && (rsp_read_attr == '0), "read fields nonzero on error status")

    // One request at a time: busy right after a transfer
    `PRMI_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")

    // A stalled result holds its valid, status, entry count and read limit
    `PRMI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count) && $stable(rsp_read_limit), "stalled result changed")

endmodule

bind protection_region_map_insert prmi_chk #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_BITS   (ADDR_BITS)
) u_prmi_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_entry_count (rsp.entry_count),
    .rsp_read_base   (rsp.read_base),
    .rsp_read_limit  (rsp.read_limit),
    .rsp_read_attr   (rsp.read_attr)
);

// ===== test/protection_region_map_insert_tb.sv =====
// Self-checking testbench for the protection region map insert block.
// Depends on prmi_pkg, prmi_if (request and response channels) and the block's RTL.
module protection_region_map_insert_tb;
    import prmi_pkg::*;

    localparam int MAX_ENTRIES = DEF_MAX_ENTRIES;
    localparam int ADDR_BITS = DEF_ADDR_BITS;
    localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [ADDR_BITS:0] ADDR_MAX = {1'b0, {ADDR_BITS{1'b1}}};
    localparam int RANDOM_ITEMS = 1924;
    localparam int HOLD_LEN = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        prmi_op_t               op;
        logic [ADDR_BITS-1:0]   base;
        logic [ADDR_BITS-1:0]   size;
        logic [ATTR_W-1:0]      attr;
        logic [IDX_W-1:0]       entry_index;
    } region_req_t;

    typedef struct {
        prmi_status_t           status;
        logic [COUNT_W-1:0]     count;
        logic [ADDR_BITS-1:0]   rd_base;
        logic [ADDR_BITS:0]     rd_limit;
        logic [ATTR_W-1:0]      rd_attr;
    } region_rsp_t;

    typedef struct {
        region_req_t    rq;
        int             reps;
        bit             typed;
        region_rsp_t    want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    prmi_req_if #(.ADDR_BITS(ADDR_BITS)) req_ch ();
    prmi_rsp_if #(.MAX_ENTRIES(MAX_ENTRIES), .ADDR_BITS(ADDR_BITS)) rsp_ch ();

    protection_region_map_insert #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .ADDR_BITS(ADDR_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // Shadow copy of the region table; a split can leave a base past the address space
    logic [ADDR_BITS:0]     map_base [MAX_ENTRIES];
    logic [ADDR_BITS:0]     map_limit [MAX_ENTRIES];
    logic [ATTR_W-1:0]      map_attr [MAX_ENTRIES];
    int map_used = 0;

    region_rsp_t pending_rsp_q [$];
    dir_row_t dir_rows [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req_seq = 0;
    int fail_count = 0;
    int results_checked = 0;
    int op_seen [4] = '{0, 0, 0, 0};
    int status_seen [4] = '{0, 0, 0, 0};
    int n_exact = 0;
    int n_split2 = 0;
    int n_split3 = 0;
    int idle_tab [4] = '{0, 50, 0, 36};
    int stall_tab [4] = '{0, 0, 50, 36};

    function automatic void store_entry(int i, logic [ADDR_BITS:0] b, logic [ADDR_BITS:0] l,
            logic [ATTR_W-1:0] a);
        map_base[i] = b;
        map_limit[i] = l;
        map_attr[i] = a;
    endfunction

    // Find the first containing entry, then replace or split it
    function automatic prmi_status_t shadow_insert(logic [ADDR_BITS:0] b,
            logic [ADDR_BITS:0] l, logic [ATTR_W-1:0] a);
        int n;
        int hit;
        logic [ADDR_BITS:0] hb;
        logic [ADDR_BITS:0] hl;
        logic [ATTR_W-1:0] ha;
        n = map_used;
        hit = -1;
        if (n >= MAX_ENTRIES)
            return ST_BOUNDS;
        for (int u = 0; u < n; u++)
            if (hit < 0 && b >= map_base[u] && l <= map_limit[u])
                hit = u;
        if (hit < 0)
            return ST_NOREGION;
        hb = map_base[hit];
        hl = map_limit[hit];
        ha = map_attr[hit];
        if (b == hb && l == hl)
        begin
            store_entry(hit, b, l, a);
            n_exact++;
        end
        else if (b == hb)
        begin
            store_entry(n, b, l, a);
            store_entry(hit, l, hl, ha);
            map_used = n + 1;
            n_split2++;
        end
        else if (l == hl)
        begin
            store_entry(hit, hb, b, ha);
            store_entry(n, b, l, a);
            map_used = n + 1;
            n_split2++;
        end
        else
        begin
            // a three-way split needs two free entries
            if (n + 2 > MAX_ENTRIES)
                return ST_FULL;
            store_entry(hit, hb, b, ha);
            store_entry(n, b, l, a);
            store_entry(n + 1, l, hl, ha);
            map_used = n + 2;
            n_split3++;
        end
        return ST_OK;
    endfunction

    // Apply one request to the shadow table and return the result it should give
    function automatic region_rsp_t apply_region_op(region_req_t rq);
        region_rsp_t r;
        logic [ADDR_BITS:0] lim;
        r.status = ST_OK;
        r.count = '0;
        r.rd_base = '0;
        r.rd_limit = '0;
        r.rd_attr = '0;
        lim = {1'b0, rq.base} + {1'b0, rq.size};
        case (rq.op)
            OP_CLEAR:
                map_used = 0;
            OP_APPEND:
                if (map_used >= MAX_ENTRIES)
                    r.status = ST_FULL;
                else
                begin
                    store_entry(map_used, {1'b0, rq.base}, lim, rq.attr);
                    map_used++;
                end
            OP_INSERT:
                r.status = shadow_insert({1'b0, rq.base}, lim, rq.attr);
            default:
                if (int'(rq.entry_index) >= map_used)
                    r.status = ST_BOUNDS;
                else
                begin
                    r.rd_base = map_base[rq.entry_index][ADDR_BITS-1:0];
                    r.rd_limit = map_limit[rq.entry_index];
                    r.rd_attr = map_attr[rq.entry_index];
                end
        endcase
        r.count = COUNT_W'(map_used);
        return r;
    endfunction

    function automatic void add_row(prmi_op_t op, logic [ADDR_BITS-1:0] b,
            logic [ADDR_BITS-1:0] s, logic [ATTR_W-1:0] a, logic [IDX_W-1:0] idx, int reps,
            bit typed, prmi_status_t st, int cnt, logic [ADDR_BITS-1:0] rb,
            logic [ADDR_BITS:0] rl, logic [ATTR_W-1:0] ra);
        dir_row_t row;
        row.rq.op = op;
        row.rq.base = b;
        row.rq.size = s;
        row.rq.attr = a;
        row.rq.entry_index = idx;
        row.reps = reps;
        row.typed = typed;
        row.want.status = st;
        row.want.count = COUNT_W'(cnt);
        row.want.rd_base = rb;
        row.want.rd_limit = rl;
        row.want.rd_attr = ra;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [ADDR_BITS-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_BITS-1:0];
    endfunction

    // Pick a point in [lo, hi], leaning toward both ends
    function automatic logic [ADDR_BITS:0] pick_between(logic [ADDR_BITS:0] lo,
            logic [ADDR_BITS:0] hi);
        logic [63:0] span;
        logic [63:0] off;
        span = 64'(hi - lo);
        case ($urandom_range(0, 3))
            0: off = 64'($urandom_range(0, 15));
            1: off = span - 64'($urandom_range(0, 15));
            default: off = {$urandom, $urandom} % (span + 1);
        endcase
        if (off > span)
            off = span;
        return lo + off[ADDR_BITS:0];
    endfunction

    // Mostly well-formed traffic: seed a background, then carve regions out of entries
    function automatic region_req_t make_random_req();
        region_req_t rq;
        int pick;
        int u;
        logic [ADDR_BITS:0] lo;
        logic [ADDR_BITS:0] hi;
        logic [ADDR_BITS:0] b;
        logic [ADDR_BITS:0] l;
        rq.op = OP_READ;
        rq.base = rand_addr();
        rq.size = rand_addr();
        rq.attr = ATTR_W'($urandom);
        rq.entry_index = IDX_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            rq.op = prmi_op_t'($urandom_range(0, 3));
            return rq;
        end
        if (map_used == 0)
        begin
            rq.op = OP_APPEND;
            rq.base = ($urandom_range(0, 1) == 0) ? '0
                                                 : rand_addr() >> $urandom_range(8, ADDR_BITS - 1);
            if ($urandom_range(0, 3) != 0)
                rq.size = ADDR_MAX[ADDR_BITS-1:0] - rq.base;
            return rq;
        end
        if (pick < 10 || (pick < 30 && map_used >= MAX_ENTRIES - 3))
        begin
            rq.op = OP_CLEAR;
            return rq;
        end
        if (pick < 30)
        begin
            if ($urandom_range(0, 3) != 0)
                rq.entry_index = IDX_W'($urandom_range(0, map_used - 1));
            return rq;
        end
        if (pick < 38)
        begin
            rq.op = OP_APPEND;
            rq.size = rand_addr() >> $urandom_range(0, ADDR_BITS - 1);
            return rq;
        end
        // keep new bases addressable when a limit runs past the address space
        u = $urandom_range(0, map_used - 1);
        lo = map_base[u];
        hi = (map_limit[u] > ADDR_MAX) ? ADDR_MAX : map_limit[u];
        if (hi < lo)
            hi = lo;
        case ($urandom_range(0, 4))
            0:
            begin
                b = lo;
                l = map_limit[u];
            end
            1:
            begin
                b = lo;
                l = pick_between(lo, hi);
            end
            2:
            begin
                b = pick_between(lo, hi);
                l = map_limit[u];
            end
            3:
            begin
                b = pick_between(lo, hi);
                l = pick_between(b, hi);
            end
            default:
            begin
                b = pick_between(lo, hi);
                l = b;
            end
        endcase
        rq.op = OP_INSERT;
        rq.base = b[ADDR_BITS-1:0];
        rq.size = ADDR_BITS'(l - b);
        return rq;
    endfunction

    // Offer one request, hold it until the transfer, then queue its expected result
    task automatic send_req(input region_req_t rq, input bit typed, input region_rsp_t want);
        region_rsp_t exp;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op <= rq.op;
        req_ch.base <= rq.base;
        req_ch.size <= rq.size;
        req_ch.attr <= rq.attr;
        req_ch.entry_index <= rq.entry_index;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        exp = apply_region_op(rq);
        if (typed)
            exp = want;
        pending_rsp_q.push_back(exp);
        op_seen[int'(rq.op)]++;
    endtask

    // Drop valid and hold off until every expected result has arrived
    task automatic wait_for_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : rsp_check
        region_rsp_t exp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("result with nothing expected: status %0d, count %0d",
                       rsp_ch.status, rsp_ch.entry_count);
                fail_count++;
            end
            else
            begin
                exp = pending_rsp_q.pop_front();
                check_field("status", exp.status, rsp_ch.status);
                check_field("entry_count", exp.count, rsp_ch.entry_count);
                check_field("read_base", exp.rd_base, rsp_ch.read_base);
                check_field("read_limit", exp.rd_limit, rsp_ch.read_limit);
                check_field("read_attr", exp.rd_attr, rsp_ch.read_attr);
                status_seen[int'(exp.status)]++;
                results_checked++;
            end
        end
    end

    // Drive ready: random stalls, plus a long hold-off on request
    initial
    begin : rsp_drive
        int hold_left;
        int seen;
        hold_left = 0;
        seen = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (seen != hold_req_seq)
            begin
                seen = hold_req_seq;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // End the run when no transfer happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        region_req_t rq;
        region_rsp_t no_check;
        no_check.status = ST_OK;
        no_check.count = '0;
        no_check.rd_base = '0;
        no_check.rd_limit = '0;
        no_check.rd_attr = '0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_CLEAR;
        req_ch.base = '0;
        req_ch.size = '0;
        req_ch.attr = '0;
        req_ch.entry_index = '0;

        // Directed rows: empty table, background seed, each insert shape, full table
        add_row(OP_READ, 48'h0, 48'h0, 16'h0, 4'h0, 1, 1'b1,
                ST_BOUNDS, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_INSERT, 48'h0, 48'h1, 16'h1, 4'h0, 1, 1'b1,
                ST_NOREGION, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_APPEND, 48'h0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 4'h0, 1, 1'b1,
                ST_OK, 1, 48'h0, 49'h0, 16'h0);
        add_row(OP_READ, 48'h0, 48'h0, 16'h0, 4'h0, 1, 1'b1,
                ST_OK, 1, 48'h0, 49'h0_FFFF_FFFF_FFFF, 16'hFFFF);
        add_row(OP_INSERT, 48'h0, 48'h1000, 16'h0001, 4'h0, 1, 1'b1,
                ST_OK, 2, 48'h0, 49'h0, 16'h0);
        add_row(OP_READ, 48'h0, 48'h0, 16'h0, 4'h0, 1, 1'b0, ST_OK, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_READ, 48'h0, 48'h0, 16'h0, 4'h1, 1, 1'b0, ST_OK, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_INSERT, 48'hFFFF_FFFF_0000, 48'hFFFF, 16'h0002, 4'h0, 1, 1'b0,
                ST_OK, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_INSERT, 48'h2000, 48'h1000, 16'h0003, 4'h0, 1, 1'b0,
                ST_OK, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_INSERT, 48'h2000, 48'h1000, 16'hABCD, 4'h0, 1, 1'b0,
                ST_OK, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_INSERT, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'h8000, 4'h0, 1, 1'b1,
                ST_NOREGION, 5, 48'h0, 49'h0, 16'h0);
        add_row(OP_INSERT, 48'h5000, 48'h0, 16'h0004, 4'h0, 1, 1'b0,
                ST_OK, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_READ, 48'h0, 48'h0, 16'h0, 4'hF, 1, 1'b1,
                ST_BOUNDS, 7, 48'h0, 49'h0, 16'h0);
        // four three-way splits in the tail entry bring the count to 15
        add_row(OP_INSERT, 48'h10000, 48'h100, 16'h0010, 4'h0, 4, 1'b0,
                ST_OK, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_INSERT, 48'h20000, 48'h100, 16'h0005, 4'h0, 1, 1'b1,
                ST_FULL, 15, 48'h0, 49'h0, 16'h0);
        add_row(OP_INSERT, 48'h0, 48'h800, 16'h0006, 4'h0, 1, 1'b0,
                ST_OK, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_APPEND, 48'h20000, 48'h10, 16'h0007, 4'h0, 1, 1'b1,
                ST_FULL, 16, 48'h0, 49'h0, 16'h0);
        add_row(OP_INSERT, 48'h0, 48'h800, 16'h0008, 4'h0, 1, 1'b1,
                ST_BOUNDS, 16, 48'h0, 49'h0, 16'h0);
        add_row(OP_READ, 48'h0, 48'h0, 16'h0, 4'hF, 1, 1'b0, ST_OK, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_READ, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 4'h0, 1, 1'b0,
                ST_OK, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_CLEAR, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 4'hF, 1, 1'b1,
                ST_OK, 0, 48'h0, 49'h0, 16'h0);
        add_row(OP_READ, 48'h0, 48'h0, 16'h0, 4'h0, 1, 1'b1,
                ST_BOUNDS, 0, 48'h0, 49'h0, 16'h0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the table; repeated rows step the base by twice the size
        foreach (dir_rows[i])
            for (int r = 0; r < dir_rows[i].reps; r++)
            begin
                rq = dir_rows[i].rq;
                rq.base = rq.base + ADDR_BITS'(2 * r) * rq.size;
                send_req(rq, dir_rows[i].typed, dir_rows[i].want);
            end
        wait_for_results();

        // Random phases with different idle and stall mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_tab[ph];
            stall_pct = stall_tab[ph];
            if (ph == 0)
                hold_req_seq++;
            for (int k = 0; k < RANDOM_ITEMS / 4; k++)
                send_req(make_random_req(), 1'b0, no_check);
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d requests (clear %0d, append %0d, insert %0d, read %0d), %0d checked.",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], results_checked);
        $display("Inserts: %0d exact, %0d two-way, %0d three-way; status %0d/%0d/%0d/%0d.",
                 n_exact, n_split2, n_split3,
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
